### hw/rtl/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// Types and constants shared by the XMODEM receiver modules.
// ----------------------------------------------------------------------------
package xmr_pkg;

  localparam int BLOCK_BYTES_DEF = 128;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  typedef enum logic [2:0] {
    PH_READY   = 3'd0,
    PH_NUMBER  = 3'd1,
    PH_CHECK   = 3'd2,
    PH_DATA    = 3'd3,
    PH_SUM     = 3'd4,
    PH_ERROR   = 3'd5,
    PH_STOPPED = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAK  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] packet_number;
    logic [6:0] byte_index;
    phase_t     state;
  } res_t;

endpackage

### hw/rtl/xmr_fsm.sv
// ----------------------------------------------------------------------------
// xmr_fsm
// Input word register and protocol FSM; forms at most one result per word.
// ----------------------------------------------------------------------------
module xmr_fsm #(
  parameter int BLOCK_BYTES = xmr_pkg::BLOCK_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  input  logic          out_free,
  output logic          res_vld,
  output xmr_pkg::res_t res
);

  localparam int CW = (BLOCK_BYTES < 2) ? 1 : $clog2(BLOCK_BYTES + 1);

  logic             in_vld_r, in_vld_nxt;
  logic             cmd_r;
  logic [7:0]       byte_r;
  logic             adv;

  xmr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       pkt_r, pkt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [6:0]       idx7;

  assign adv        = in_vld_r && out_free;
  assign in_tready  = !in_vld_r || out_free;
  assign in_vld_nxt = (in_tvalid && in_tready) ? 1'b1 : (adv ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    pkt_nxt   = pkt_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    if (cmd_r == xmr_pkg::CMD_START) begin
      pkt_nxt   = 8'd0;
      phase_nxt = xmr_pkg::PH_READY;
    end else begin
      case (phase_r)
        xmr_pkg::PH_READY: begin
          if (byte_r == xmr_pkg::BYTE_SOH) begin
            phase_nxt = xmr_pkg::PH_NUMBER;
            sum_nxt   = 8'd0;
          end else if (byte_r == xmr_pkg::BYTE_EOT || byte_r == xmr_pkg::BYTE_CAN) begin
            phase_nxt = xmr_pkg::PH_STOPPED;
          end
        end
        xmr_pkg::PH_NUMBER: begin
          pkt_nxt   = byte_r;
          phase_nxt = xmr_pkg::PH_CHECK;
        end
        xmr_pkg::PH_CHECK: begin
          if (~byte_r == pkt_r) begin
            phase_nxt = xmr_pkg::PH_DATA;
            sum_nxt   = 8'd0;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = xmr_pkg::PH_ERROR;
          end
        end
        xmr_pkg::PH_DATA: begin
          sum_nxt = sum_r + byte_r;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt == CW'(BLOCK_BYTES)) begin
            phase_nxt = xmr_pkg::PH_SUM;
          end
        end
        xmr_pkg::PH_SUM: begin
          phase_nxt = xmr_pkg::PH_READY;
        end
        default: begin
        end
      endcase
    end
  end

  assign idx7 = 7'(cnt_r);

  // Outputs
  always_comb begin
    res_vld           = 1'b0;
    res.kind          = xmr_pkg::KIND_NAK;
    res.data_byte     = 8'd0;
    res.packet_number = pkt_nxt;
    res.byte_index    = 7'd0;
    res.state         = phase_nxt;
    if (cmd_r == xmr_pkg::CMD_START) begin
      res_vld = adv;
    end else begin
      case (phase_r)
        xmr_pkg::PH_READY: begin
          if (byte_r == xmr_pkg::BYTE_EOT) begin
            res_vld  = adv;
            res.kind = xmr_pkg::KIND_ACK;
          end
        end
        xmr_pkg::PH_DATA: begin
          res_vld        = adv;
          res.kind       = xmr_pkg::KIND_DATA;
          res.data_byte  = byte_r;
          res.byte_index = idx7;
        end
        xmr_pkg::PH_SUM: begin
          res_vld  = adv;
          res.kind = (byte_r == sum_r) ? xmr_pkg::KIND_ACK : xmr_pkg::KIND_NAK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xmr_pkg::PH_STOPPED;
      pkt_r   <= 8'd0;
      sum_r   <= 8'd0;
      cnt_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pkt_r   <= pkt_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cmd_r == xmr_pkg::CMD_START |=> phase_r == xmr_pkg::PH_READY && pkt_r == 8'd0)
    else $error("start did not clear receiver");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == xmr_pkg::PH_DATA |-> cnt_r < CW'(BLOCK_BYTES))
    else $error("data count out of range");

  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.kind == xmr_pkg::KIND_DATA |-> phase_r == xmr_pkg::PH_DATA)
    else $error("data result outside data phase");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == xmr_pkg::PH_ERROR && cmd_r == xmr_pkg::CMD_BYTE
      |=> phase_r == xmr_pkg::PH_ERROR)
    else $error("error state left without start");

  a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> out_free)
    else $error("result formed with output full");

endmodule

### hw/rtl/xmr_out_reg.sv
// ----------------------------------------------------------------------------
// xmr_out_reg
// Result register holding one reply word until the consumer takes it.
// ----------------------------------------------------------------------------
module xmr_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_vld,
  input  xmr_pkg::res_t res,
  output logic          out_free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic [1:0]    out_tuser
);

  logic          vld_r, vld_nxt;
  xmr_pkg::res_t res_r;

  assign out_free = !vld_r || out_tready;
  assign vld_nxt  = res_vld ? 1'b1 : (out_tready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {6'd0, res_r.state, res_r.byte_index, res_r.packet_number,
                       res_r.data_byte};

endmodule

### hw/rtl/xmodem_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_receiver
// XMODEM checksum receiver: start/byte words in, NAK/ACK/data replies out.
// Reply path: input word into the input register, reply word from the result register.
// Throughput: one word per cycle while out_tready is high; every word, with
// or without a reply, waits for a free result register.
// Reset: synchronous active-low; enters stopped, packet/sum/count cleared.
// ----------------------------------------------------------------------------
module xmodem_receiver #(
  parameter int BLOCK_BYTES = xmr_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [15:8] packet_number,
                                  // [22:16] byte_index, [25:23] receiver_state
  output logic [1:0]  out_tuser   // [1:0] reply_kind
);

  logic          out_free;
  logic          res_vld;
  xmr_pkg::res_t res;

  xmr_fsm #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .out_free (out_free),
    .res_vld  (res_vld),
    .res      (res)
  );

  xmr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XMODEM checksum receiver. A short table of
// start commands and line bytes hits the special cases: bytes ignored while
// stopped or in error, EOT, CAN, a bad complement, and starts in several phases.
// Random packets follow, most of them well formed, with random, all-zero or
// all-ones content. Each accepted word goes through a local receiver model, and
// the replies are checked against it under changing source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int PKT_BYTES = xmr_pkg::BLOCK_BYTES_DEF;
  localparam int RAND_WORDS = 640;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_TYPED
  } exp_t;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_t;

  typedef struct packed {
    xmr_pkg::cmd_t cmd;
    logic [7:0]    b;
    exp_t          how;
    xmr_pkg::res_t r;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // receiver model state
  xmr_pkg::phase_t xp_phase = xmr_pkg::PH_STOPPED;
  logic [7:0]      xp_pkt = 8'h00;
  logic [7:0]      xp_sum = 8'h00;
  logic [7:0]      xp_cnt = 8'h00;

  xmr_pkg::res_t reply_queue[$];
  flow_t         flow = FLOW_FREE;
  int            errors = 0;
  int            words_sent = 0;

  row_t dir_rows [26] = '{
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_NONE,  '0},
    '{xmr_pkg::CMD_BYTE,  8'hFF,             EXP_NONE,  '0},
    '{xmr_pkg::CMD_START, 8'hFF,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  8'h00,             EXP_NONE,  '0},
    '{xmr_pkg::CMD_BYTE,  8'hFF,             EXP_NONE,  '0},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_EOT, EXP_TYPED,
      '{xmr_pkg::KIND_ACK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_STOPPED}},
    '{xmr_pkg::CMD_START, 8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_CAN, EXP_NONE,  '0},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_NONE,  '0},
    '{xmr_pkg::CMD_START, 8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'h05,             EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'h00,             EXP_NONE,  '0},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_NONE,  '0},
    '{xmr_pkg::CMD_START, 8'h5A,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'hFF,             EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'h00,             EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_DATA, 8'h00, 8'hFF, 7'd0, xmr_pkg::PH_DATA}},
    '{xmr_pkg::CMD_BYTE,  8'hFF,             EXP_TYPED,
      '{xmr_pkg::KIND_DATA, 8'hFF, 8'hFF, 7'd1, xmr_pkg::PH_DATA}},
    '{xmr_pkg::CMD_START, 8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_MODEL, '0},
    '{xmr_pkg::CMD_BYTE,  8'h00,             EXP_MODEL, '0},
    '{xmr_pkg::CMD_START, 8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}},
    '{xmr_pkg::CMD_BYTE,  xmr_pkg::BYTE_SOH, EXP_MODEL, '0},
    '{xmr_pkg::CMD_START, 8'h00,             EXP_TYPED,
      '{xmr_pkg::KIND_NAK, 8'h00, 8'h00, 7'd0, xmr_pkg::PH_READY}}
  };

  xmodem_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic rx_predict(input xmr_pkg::cmd_t c, input logic [7:0] b, output bit has,
                            output xmr_pkg::res_t r);
    logic [7:0] idx;
    has = 1'b0;
    r = '0;
    idx = 8'h00;
    if (c == xmr_pkg::CMD_START) begin
      xp_pkt = 8'h00;
      xp_phase = xmr_pkg::PH_READY;
      has = 1'b1;
      r.kind = xmr_pkg::KIND_NAK;
    end else begin
      case (xp_phase)
        xmr_pkg::PH_READY: begin
          if (b == xmr_pkg::BYTE_SOH) begin
            xp_phase = xmr_pkg::PH_NUMBER;
            xp_sum = 8'h00;
          end else if (b == xmr_pkg::BYTE_EOT) begin
            xp_phase = xmr_pkg::PH_STOPPED;
            has = 1'b1;
            r.kind = xmr_pkg::KIND_ACK;
          end else if (b == xmr_pkg::BYTE_CAN) begin
            xp_phase = xmr_pkg::PH_STOPPED;
          end
        end
        xmr_pkg::PH_NUMBER: begin
          xp_pkt = b;
          xp_phase = xmr_pkg::PH_CHECK;
        end
        xmr_pkg::PH_CHECK: begin
          if ((b ^ 8'hFF) == xp_pkt) begin
            xp_phase = xmr_pkg::PH_DATA;
            xp_sum = 8'h00;
            xp_cnt = 8'h00;
          end else begin
            xp_phase = xmr_pkg::PH_ERROR;
          end
        end
        xmr_pkg::PH_DATA: begin
          idx = xp_cnt;
          xp_sum = xp_sum + b;
          xp_cnt = xp_cnt + 8'd1;
          if (xp_cnt >= PKT_BYTES) xp_phase = xmr_pkg::PH_SUM;
          has = 1'b1;
          r.kind = xmr_pkg::KIND_DATA;
          r.data_byte = b;
          r.byte_index = idx[6:0];
        end
        xmr_pkg::PH_SUM: begin
          xp_phase = xmr_pkg::PH_READY;
          has = 1'b1;
          r.kind = (b == xp_sum) ? xmr_pkg::KIND_ACK : xmr_pkg::KIND_NAK;
        end
        default: ;
      endcase
    end
    if (has) begin
      r.packet_number = xp_pkt;
      r.state = xp_phase;
    end
  endtask

  task automatic send_word(input xmr_pkg::cmd_t c, input logic [7:0] b, input exp_t how,
                           input xmr_pkg::res_t typed);
    bit            has;
    xmr_pkg::res_t r;
    int            gap_pct;
    gap_pct = (flow == FLOW_SRC_GAPS) ? 51 : (flow == FLOW_BOTH) ? 14 : 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rx_predict(c, b, has, r);
    if (how == EXP_NONE) begin
      has = 1'b0;
    end else if (how == EXP_TYPED) begin
      has = 1'b1;
      r = typed;
    end
    if (has) reply_queue.push_back(r);
    words_sent++;
  endtask

  always @(posedge clk) begin
    case (flow)
      FLOW_SINK_STALLS: out_tready <= ($urandom_range(99) >= 51);
      FLOW_BOTH:        out_tready <= ($urandom_range(99) >= 14);
      default:          out_tready <= rst_n;
    endcase
  end

  always @(posedge clk) begin
    xmr_pkg::res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_queue.size() == 0) begin
        $error("reply word with none pending: kind %0d tdata %h", out_tuser, out_tdata);
        errors++;
      end else begin
        e = reply_queue.pop_front();
        if (out_tuser !== e.kind) begin
          $error("reply_kind: expected %0d, actual %0d", e.kind, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== e.data_byte) begin
          $error("data_byte: expected %h, actual %h", e.data_byte, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== e.packet_number) begin
          $error("packet_number: expected %h, actual %h", e.packet_number,
                 out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[22:16] !== e.byte_index) begin
          $error("byte_index: expected %0d, actual %0d", e.byte_index, out_tdata[22:16]);
          errors++;
        end
        if (out_tdata[25:23] !== e.state) begin
          $error("receiver_state: expected %0d, actual %0d", e.state, out_tdata[25:23]);
          errors++;
        end
      end
    end
  end

  initial begin
    int         pick;
    int         fill;
    int         k;
    int         rand_base;
    logic [7:0] n;
    logic [7:0] b;
    logic [7:0] sum;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cmd, dir_rows[i].b, dir_rows[i].how, dir_rows[i].r);
    end

    rand_base = words_sent;
    while (words_sent - rand_base < RAND_WORDS) begin
      flow = flow_t'(((words_sent - rand_base) / 150) % 4);
      if (xp_phase != xmr_pkg::PH_READY) begin
        send_word(xmr_pkg::CMD_START, 8'($urandom_range(255)), EXP_MODEL, '0);
        continue;
      end
      pick = $urandom_range(99);
      n = 8'($urandom_range(255));
      if (pick < 55) begin
        // full packet, checksum good three times in four
        fill = $urandom_range(3);
        sum = 8'h00;
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_SOH, EXP_MODEL, '0);
        send_word(xmr_pkg::CMD_BYTE, n, EXP_MODEL, '0);
        send_word(xmr_pkg::CMD_BYTE, ~n, EXP_MODEL, '0);
        for (k = 0; k < PKT_BYTES; k++) begin
          b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(255));
          sum = sum + b;
          send_word(xmr_pkg::CMD_BYTE, b, EXP_MODEL, '0);
        end
        if ($urandom_range(3) == 0) sum = sum + 8'($urandom_range(255, 1));
        send_word(xmr_pkg::CMD_BYTE, sum, EXP_MODEL, '0);
      end else if (pick < 63) begin
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT, EXP_MODEL, '0);
      end else if (pick < 71) begin
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_CAN, EXP_MODEL, '0);
      end else if (pick < 81) begin
        // bad complement, then line noise while in error
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_SOH, EXP_MODEL, '0);
        send_word(xmr_pkg::CMD_BYTE, n, EXP_MODEL, '0);
        send_word(xmr_pkg::CMD_BYTE, ~n ^ 8'($urandom_range(255, 1)), EXP_MODEL, '0);
        repeat ($urandom_range(4)) begin
          send_word(xmr_pkg::CMD_BYTE, 8'($urandom_range(255)), EXP_MODEL, '0);
        end
      end else if (pick < 93) begin
        // packet cut short by a start, up to the checksum phase
        k = $urandom_range(PKT_BYTES + 3);
        if (k > 0) send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_SOH, EXP_MODEL, '0);
        if (k > 1) send_word(xmr_pkg::CMD_BYTE, n, EXP_MODEL, '0);
        if (k > 2) send_word(xmr_pkg::CMD_BYTE, ~n, EXP_MODEL, '0);
        repeat ((k > 3) ? k - 3 : 0) begin
          send_word(xmr_pkg::CMD_BYTE, 8'($urandom_range(255)), EXP_MODEL, '0);
        end
        send_word(xmr_pkg::CMD_START, 8'($urandom_range(255)), EXP_MODEL, '0);
      end else begin
        send_word(xmr_pkg::CMD_BYTE, 8'($urandom_range(255)), EXP_MODEL, '0);
      end
    end

    flow = FLOW_FREE;
    in_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
